>>> src/assert_macros.svh
// assertion helpers for the register file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

>>> src/svga_erf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svga_erf_pkg
// types and constants shared by the extended register file
// ----------------------------------------------------------------------------
package svga_erf_pkg;
  localparam logic [1:0] REQ_CRTC_WR = 2'd0;
  localparam logic [1:0] REQ_CRTC_RD = 2'd1;
  localparam logic [1:0] REQ_SEQ_WR  = 2'd2;
  localparam logic [1:0] REQ_SEQ_RD  = 2'd3;

  localparam logic CFG_VRAM_KB     = 1'b0;
  localparam logic CFG_RESET_STRAP = 1'b1;

  localparam logic [7:0] BANK_KEY = 8'h48;
  localparam logic [7:0] PLL_KEY  = 8'h06;
  localparam logic [7:0] SEQ_LOCK_LIMIT = 8'h1b;
  localparam logic [7:0] CURSOR_MODE_SET = 8'ha0;

  function automatic logic [7:0] rotate_value(input logic [1:0] p);
    unique case (p)
      2'd0: rotate_value = 8'h7b;
      2'd1: rotate_value = 8'hc0;
      2'd2: rotate_value = 8'h00;
      default: rotate_value = 8'hda;
    endcase
  endfunction

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] reg_index;
    logic [7:0] write_value;
    logic       attr_disabled;
    logic [4:0] attr_index;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [6:0] bank_number;
    logic [4:0] start_high;
    logic [1:0] offset_high;
    logic       line_compare_high;
    logic       cursor_enabled;
    logic       remap_event;
    logic       resize_event;
    logic       window_event;
    logic       mode_event;
  } rsp_t;
endpackage
`default_nettype wire

>>> src/svga_extended_register_file.sv
`timescale 1ns / 1ps
`default_nettype none
// one access per cycle while in_stall is low; the result is registered and appears in the cycle after the transfer
// throughput one item per clock while in_stall is low, set by the single decode stage
// output register holds a result while the output stalls
// sync reset clears out_valid and the core registers to zero, vram_kb to 2048, reset_strap to 154
// ----------------------------------------------------------------------------
// svga_extended_register_file
// extended crtc and sequencer register file top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module svga_extended_register_file import svga_erf_pkg::*; #(
  parameter int STACK_DEPTH = 3
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [14:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  req_type,
  input  wire logic [7:0]  reg_index,
  input  wire logic [7:0]  write_value,
  input  wire logic        attr_disabled,
  input  wire logic [4:0]  attr_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       read_data,
  output logic [6:0]       bank_number,
  output logic [4:0]       start_high,
  output logic [1:0]       offset_high,
  output logic             line_compare_high,
  output logic             cursor_enabled,
  output logic             remap_event,
  output logic             resize_event,
  output logic             window_event,
  output logic             mode_event
);
  logic [14:0] vram_kb;
  logic [7:0]  reset_strap;
  logic step;
  req_t req;
  rsp_t rsp, rsp_q;

  assign cfg_ready = 1'b1;
  assign in_stall = out_valid && out_stall;
  assign step = in_valid && !in_stall;
  assign req = '{req_type, reg_index, write_value, attr_disabled, attr_index};

  always_ff @(posedge clk) begin
    if (rst) begin
      vram_kb <= 15'd2048;
      reset_strap <= 8'd154;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_VRAM_KB: vram_kb <= cfg_data;
        default: reset_strap <= cfg_data[7:0];
      endcase
    end
  end

  svga_erf_core #(.STACK_DEPTH(STACK_DEPTH)) u_core (
    .clk, .rst, .step, .req, .vram_kb, .reset_strap, .rsp
  );

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (!in_stall) out_valid <= step;
  end
  always_ff @(posedge clk) begin
    if (step) rsp_q <= rsp;
  end

  assign read_data = rsp_q.read_data;
  assign bank_number = rsp_q.bank_number;
  assign start_high = rsp_q.start_high;
  assign offset_high = rsp_q.offset_high;
  assign line_compare_high = rsp_q.line_compare_high;
  assign cursor_enabled = rsp_q.cursor_enabled;
  assign remap_event = rsp_q.remap_event;
  assign resize_event = rsp_q.resize_event;
  assign window_event = rsp_q.window_event;
  assign mode_event = rsp_q.mode_event;

  `ASSERT_IMPL(a_hold, clk, rst, (out_valid && out_stall) |=> out_valid && $stable(read_data))
  `ASSERT_IMPL(a_fill, clk, rst, (in_valid && !in_stall) |=> out_valid)
  `ASSERT_NEVER(a_no_take, clk, rst, in_stall && !out_valid)
endmodule
`default_nettype wire

>>> src/svga_erf_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svga_erf_core
// register state and combinational decode of one access
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module svga_erf_core import svga_erf_pkg::*; #(
  parameter int STACK_DEPTH = 3
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire req_t        req,
  input  wire logic [14:0] vram_kb,
  input  wire logic [7:0]  reset_strap,
  output rsp_t             rsp
);
  localparam logic [1:0] STACK_LAST = 2'(STACK_DEPTH - 1);

  logic [7:0]  lock_one, lock_two, cursor_mode;
  logic [7:0]  r31, r3a, r40, r41, r42, r43, r50, r51, r52, r53, r55, r58, r5d, r5e, r67, r6b;
  logic [3:0]  lock_high_nibble;
  logic [6:0]  bank;
  logic [4:0]  start_bits;
  logic [1:0]  width_bits;
  logic [15:0] origin_x, origin_y, window_pos;
  logic [11:0] cursor_start;
  logic [5:0]  pat_x, pat_y;
  logic [7:0]  fore_stack [4];
  logic [7:0]  back_stack [4];
  logic [1:0]  fptr, bptr, rotate_ptr;
  logic [7:0]  pll_unlock;
  logic [7:0]  pll_words [5];

  logic [7:0] v, ri, rd;
  logic wr_crtc, rd_crtc, wr_seq, rd_seq, seq_locked;
  logic remap, resize, window, mode;
  logic [1:0] fslot, bslot;
  logic [6:0] bank51;
  logic [12:0] cs_plus;

  assign v = req.write_value;
  assign ri = req.reg_index;
  assign wr_crtc = step && req.req_type == REQ_CRTC_WR;
  assign rd_crtc = step && req.req_type == REQ_CRTC_RD;
  assign wr_seq = step && req.req_type == REQ_SEQ_WR;
  assign rd_seq = step && req.req_type == REQ_SEQ_RD;
  assign seq_locked = ri > 8'd8 && pll_unlock != PLL_KEY;
  // pointer wraps before the store
  assign fslot = (fptr > STACK_LAST) ? 2'd0 : fptr;
  assign bslot = (bptr > STACK_LAST) ? 2'd0 : bptr;
  assign bank51 = {bank[6], v[3:2], bank[3:0]};
  assign cs_plus = {1'b0, v[3:0], cursor_start[7:0]} + 13'd1;

  always_comb begin
    rd = 8'd0;
    unique case (req.req_type)
      REQ_CRTC_RD: begin
        unique case (ri)
          8'h24, 8'h26: rd = {2'b00, ~req.attr_disabled, req.attr_index};
          8'h2d: rd = 8'h88;
          8'h2e: rd = 8'h11;
          8'h30: rd = 8'he1;
          8'h31: rd = r31;
          8'h35: rd = {lock_high_nibble, bank[3:0]};
          8'h36: rd = reset_strap;
          8'h37: rd = 8'h2b;
          8'h38: rd = lock_one;
          8'h39: rd = lock_two;
          8'h3a: rd = r3a;
          8'h40: rd = r40;
          8'h41: rd = r41;
          8'h42: rd = 8'h0d;
          8'h43: rd = r43 | {5'd0, width_bits[0], 2'd0};
          8'h45: rd = cursor_mode | CURSOR_MODE_SET;
          8'h46: rd = origin_x[15:8];
          8'h47: rd = origin_x[7:0];
          8'h48: rd = origin_y[15:8];
          8'h49: rd = origin_y[7:0];
          8'h4a: rd = fore_stack[fptr];
          8'h4b: rd = back_stack[bptr];
          8'h50: rd = r50;
          8'h51: rd = {2'b00, width_bits, bank[5:4], start_bits[3:2]} | r51;
          8'h52: rd = r52;
          8'h53: rd = r53;
          8'h55: rd = r55;
          8'h58: rd = r58;
          8'h59: rd = window_pos[15:8];
          8'h5a: rd = window_pos[7:0];
          8'h5d: rd = r5d;
          8'h5e: rd = r5e;
          8'h67: rd = r67;
          8'h69: rd = {3'd0, start_bits};
          8'h6a: rd = {1'b0, bank};
          8'h6b: rd = r6b;
          default: rd = 8'd0;
        endcase
      end
      REQ_SEQ_RD: begin
        if (seq_locked) begin
          rd = (ri < SEQ_LOCK_LIMIT) ? 8'd0 : ri;
        end else begin
          unique case (ri)
            8'h08: rd = pll_unlock;
            8'h10: rd = pll_words[0];
            8'h11: rd = pll_words[1];
            8'h12: rd = pll_words[2];
            8'h13: rd = pll_words[3];
            8'h15: rd = pll_words[4];
            8'h17: rd = rotate_value(rotate_ptr);
            default: rd = 8'd0;
          endcase
        end
      end
      default: rd = 8'd0;
    endcase
  end

  always_comb begin
    remap = 1'b0; resize = 1'b0; window = 1'b0; mode = 1'b0;
    if (wr_crtc) begin
      unique case (ri)
        8'h31: begin mode = 1'b1; remap = 1'b1; end
        8'h35: remap = lock_one == BANK_KEY && bank[3:0] != v[3:0];
        8'h42: resize = v[5] != r42[5];
        8'h43: resize = width_bits[0] != v[2];
        8'h51: begin
          remap = bank51 != bank;
          resize = v[5:4] != width_bits;
        end
        8'h53: remap = r53 != v;
        8'h58: window = 1'b1;
        8'h59: window = window_pos[15:8] != v;
        8'h5a: window = window_pos[7:0] != v;
        8'h5d: resize = v[1:0] != r5d[1:0];
        8'h5e: resize = v[1:0] != r5e[1:0];
        8'h67: mode = 1'b1;
        8'h6a: remap = 1'b1;
        default: ;
      endcase
    end
    if (wr_seq && !seq_locked && ri == 8'h15) resize = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_one <= '0; lock_two <= '0; cursor_mode <= '0;
      r31 <= '0; r3a <= '0; r40 <= '0; r41 <= '0; r42 <= '0; r43 <= '0;
      r50 <= '0; r51 <= '0; r52 <= '0; r53 <= '0; r55 <= '0; r58 <= '0;
      r5d <= '0; r5e <= '0; r67 <= '0; r6b <= '0;
      lock_high_nibble <= '0; bank <= '0; start_bits <= '0; width_bits <= '0;
      origin_x <= '0; origin_y <= '0; window_pos <= '0; cursor_start <= '0;
      pat_x <= '0; pat_y <= '0; fptr <= '0; bptr <= '0; rotate_ptr <= '0;
      pll_unlock <= '0;
      for (int i = 0; i < 4; i++) begin
        fore_stack[i] <= '0; back_stack[i] <= '0;
      end
      for (int i = 0; i < 5; i++) pll_words[i] <= '0;
    end else begin
      if (wr_crtc) begin
        unique case (ri)
          8'h31: begin r31 <= v; start_bits[1:0] <= v[5:4]; end
          8'h35: if (lock_one == BANK_KEY) begin
            lock_high_nibble <= v[7:4]; bank[3:0] <= v[3:0];
          end
          8'h38: lock_one <= v;
          8'h39: lock_two <= v;
          8'h3a: r3a <= v;
          8'h40: r40 <= v;
          8'h41: r41 <= v;
          8'h42: r42 <= v;
          8'h43: begin r43 <= v & 8'hfb; width_bits[0] <= v[2]; end
          8'h45: cursor_mode <= v;
          8'h46: origin_x[15:8] <= v;
          8'h47: origin_x[7:0] <= v;
          8'h48: origin_y[15:8] <= v;
          8'h49: origin_y[7:0] <= v;
          8'h4a: begin fore_stack[fslot] <= v; fptr <= fslot + 2'd1; end
          8'h4b: begin back_stack[bslot] <= v; bptr <= bslot + 2'd1; end
          8'h4c: cursor_start[11:8] <=
                 ({2'b00, cs_plus} > vram_kb) ? 4'd0 : v[3:0];
          8'h4d: cursor_start[7:0] <= v;
          8'h4e: pat_x <= v[5:0];
          8'h4f: pat_y <= v[5:0];
          8'h50: r50 <= v;
          8'h51: begin
            r51 <= v & 8'hc0; start_bits[3:2] <= v[1:0];
            bank <= bank51; width_bits <= v[5:4];
          end
          8'h52: r52 <= v;
          8'h53: r53 <= v;
          8'h55: r55 <= v;
          8'h58: r58 <= v;
          8'h59: window_pos[15:8] <= v;
          8'h5a: window_pos[7:0] <= v;
          8'h5d: r5d <= v;
          8'h5e: r5e <= v;
          8'h67: r67 <= v;
          8'h69: start_bits <= v[4:0];
          8'h6a: bank <= v[6:0];
          8'h6b: r6b <= v;
          default: ;
        endcase
      end
      if (rd_crtc && ri == 8'h45) begin
        fptr <= '0; bptr <= '0;
      end
      if (wr_seq && !seq_locked) begin
        unique case (ri)
          8'h08: pll_unlock <= v;
          8'h10: pll_words[0] <= v;
          8'h11: pll_words[1] <= {1'b0, v[6:0]};
          8'h12: pll_words[2] <= v;
          8'h13: pll_words[3] <= {1'b0, v[6:0]};
          8'h15: pll_words[4] <= v;
          default: ;
        endcase
      end
      if (rd_seq && !seq_locked && ri == 8'h17) rotate_ptr <= rotate_ptr + 2'd1;
    end
  end

  // result reflects state after the access
  always_comb begin
    rsp.read_data = rd;
    rsp.bank_number = bank;
    rsp.start_high = start_bits;
    rsp.offset_high = width_bits;
    rsp.line_compare_high = r5e[6];
    rsp.cursor_enabled = cursor_mode[0];
    rsp.remap_event = remap;
    rsp.resize_event = resize;
    rsp.window_event = window;
    rsp.mode_event = mode;
    if (wr_crtc) begin
      unique case (ri)
        8'h31: rsp.start_high = {start_bits[4:2], v[5:4]};
        8'h35: if (lock_one == BANK_KEY) rsp.bank_number = {bank[6:4], v[3:0]};
        8'h43: rsp.offset_high = {width_bits[1], v[2]};
        8'h45: rsp.cursor_enabled = v[0];
        8'h51: begin
          rsp.start_high = {start_bits[4], v[1:0], start_bits[1:0]};
          rsp.bank_number = bank51;
          rsp.offset_high = v[5:4];
        end
        8'h5e: rsp.line_compare_high = v[6];
        8'h69: rsp.start_high = v[4:0];
        8'h6a: rsp.bank_number = v[6:0];
        default: ;
      endcase
    end
  end

  logic unused_ok;
  assign unused_ok = ^{pat_x, pat_y};

  `ASSERT_IMPL(a_ptr_range, clk, rst, (int'(fptr) <= STACK_DEPTH) && (int'(bptr) <= STACK_DEPTH))
  `ASSERT_IMPL(a_lock_bank, clk, rst, (wr_crtc && ri == 8'h35 && lock_one != BANK_KEY) |=> $stable(lock_high_nibble))
  `ASSERT_IMPL(a_seq_lock, clk, rst, (wr_seq && seq_locked) |=> $stable(pll_unlock))
endmodule
`default_nettype wire
